// File: hw/rtl/dynamic_sorted_levels_set_macros.svh
// Assertion macros used by the checker file.
`ifndef DYNAMIC_SORTED_LEVELS_SET_MACROS_SVH
`define DYNAMIC_SORTED_LEVELS_SET_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DSLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DSLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/dsls_pkg.sv
package dsls_pkg;

  localparam int unsigned LEVELS      = 10;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned LV_W        = 4;
  localparam int unsigned POS_W       = 9;
  localparam int unsigned ADDR_W      = LEVELS;
  localparam int unsigned IDX_W       = LEVELS - 1;
  localparam int unsigned LIDX_W      = $clog2(LEVELS + 1);
  localparam int unsigned SW          = LEVELS + 1;
  localparam int unsigned STORE_DEPTH = (1 << LEVELS) - 1;
  localparam int unsigned SCR_DEPTH   = 1 << LEVELS;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MRD,
    ST_MCMP,
    ST_CRD,
    ST_CWR,
    ST_SCHK,
    ST_SRD,
    ST_SCMP,
    ST_DONE
  } state_e;

endpackage

// File: hw/rtl/dynamic_sorted_levels_set.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_stall_o | in_op_i, in_value_i
// out     | output    | out_valid_o/out_stall_i | out_found_o, out_level_o,
//         |           |                      | out_position_o, out_overflow_o
// One item at a time. Insert: the carry (first the new value) is merged with
// each full lower level, one value per read (MRD) and compare (MCMP) step,
// then copied to the first empty level by read (CRD) and write (CWR) steps.
// Search: each level is checked (SCHK); full levels are binary-searched by
// read (SRD) and compare (SCMP) per probe, with one more read on a miss.
// Store reads use one port. Reset empties all levels at once; out_stall_i
// holds a finished result in the output register.
module dynamic_sorted_levels_set (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           in_op_i,
  input  logic signed [dsls_pkg::VAL_W-1:0] in_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           out_found_o,
  output logic [dsls_pkg::LV_W-1:0]      out_level_o,
  output logic [dsls_pkg::POS_W-1:0]     out_position_o,
  output logic                           out_overflow_o
);

  localparam int unsigned AW = dsls_pkg::ADDR_W;
  localparam int unsigned IW = dsls_pkg::IDX_W;
  localparam int unsigned LW = dsls_pkg::LIDX_W;
  localparam int unsigned SW = dsls_pkg::SW;

  dsls_pkg::state_e state_q, state_d;

  logic [dsls_pkg::VAL_W-1:0] store_mem [dsls_pkg::STORE_DEPTH];
  logic [dsls_pkg::VAL_W-1:0] scr_mem [dsls_pkg::SCR_DEPTH];
  logic [dsls_pkg::VAL_W-1:0] st_rd_q, sc_rd_q;

  logic [dsls_pkg::LEVELS-1:0] full_q;
  logic [LW-1:0]               lv_q, fe_q, fe_c;
  logic                        src_q;
  logic [AW-1:0]               a_q, b_q, c_q, mid_q;
  logic signed [SW-1:0]        lo_q, hi_q;
  logic signed [dsls_pkg::VAL_W-1:0] key_q;
  logic                        r_found_q, r_ovf_q;
  logic [dsls_pkg::LV_W-1:0]   r_lv_q;
  logic [dsls_pkg::POS_W-1:0]  r_pos_q;
  logic                        out_valid_q, out_found_q, out_ovf_q;
  logic [dsls_pkg::LV_W-1:0]   out_lv_q;
  logic [dsls_pkg::POS_W-1:0]  out_pos_q;

  logic          accept, out_load;
  logic [AW-1:0] len, len2, base_lv, base_fe, ab_sum, mid_c;
  logic          a_done, b_done, take_carry, merge_last, copy_last;
  logic          st_we, sc_we, st_re, sc_re;
  logic [AW-1:0] st_waddr, st_raddr, sc_waddr, sc_raddr;
  logic [dsls_pkg::VAL_W-1:0] st_wdata, sc_wdata;
  logic signed [SW-1:0] lohi_sum;

  always_comb begin
    fe_c = LW'(dsls_pkg::LEVELS);
    for (int i = dsls_pkg::LEVELS - 1; i >= 0; i--) begin
      if (!full_q[i]) begin
        fe_c = LW'(i);
      end
    end
  end

  assign len        = AW'(1) << lv_q;
  assign len2       = AW'(1) << (lv_q + LW'(1));
  assign base_lv    = (AW'(1) << lv_q) - AW'(1);
  assign base_fe    = (AW'(1) << fe_q) - AW'(1);
  assign ab_sum     = a_q + b_q;
  assign a_done     = (a_q == len);
  assign b_done     = (b_q == len);
  assign take_carry = a_done || (!b_done && ($signed(st_rd_q) >= $signed(sc_rd_q)));
  assign merge_last = ((ab_sum + AW'(1)) == len2);
  assign copy_last  = ((c_q + AW'(1)) == (AW'(1) << fe_q));
  assign lohi_sum   = lo_q + hi_q;
  assign mid_c      = AW'(lohi_sum >>> 1);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == dsls_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      dsls_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_op_i == dsls_pkg::OP_SEARCH) begin
            state_d = dsls_pkg::ST_SCHK;
          end else if (fe_c == LW'(dsls_pkg::LEVELS)) begin
            state_d = dsls_pkg::ST_DONE;
          end else if (fe_c == '0) begin
            state_d = dsls_pkg::ST_CRD;
          end else begin
            state_d = dsls_pkg::ST_MRD;
          end
        end
      end
      dsls_pkg::ST_MRD:  state_d = dsls_pkg::ST_MCMP;
      dsls_pkg::ST_MCMP: begin
        if (merge_last && (lv_q + LW'(1) == fe_q)) begin
          state_d = dsls_pkg::ST_CRD;
        end else begin
          state_d = dsls_pkg::ST_MRD;
        end
      end
      dsls_pkg::ST_CRD:  state_d = dsls_pkg::ST_CWR;
      dsls_pkg::ST_CWR:  state_d = copy_last ? dsls_pkg::ST_DONE : dsls_pkg::ST_CRD;
      dsls_pkg::ST_SCHK: begin
        if (lv_q == LW'(dsls_pkg::LEVELS)) begin
          state_d = dsls_pkg::ST_DONE;
        end else if (full_q[lv_q]) begin
          state_d = dsls_pkg::ST_SRD;
        end
      end
      dsls_pkg::ST_SRD:  state_d = (lo_q > hi_q) ? dsls_pkg::ST_SCHK : dsls_pkg::ST_SCMP;
      dsls_pkg::ST_SCMP: begin
        if ($signed(st_rd_q) == key_q) begin
          state_d = dsls_pkg::ST_DONE;
        end else begin
          state_d = dsls_pkg::ST_SRD;
        end
      end
      dsls_pkg::ST_DONE: if (out_load) state_d = dsls_pkg::ST_IDLE;
      default:           state_d = dsls_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != dsls_pkg::ST_IDLE);
    st_we      = (state_q == dsls_pkg::ST_CWR);
    st_waddr   = base_fe + c_q;
    st_wdata   = sc_rd_q;
    st_re      = (state_q == dsls_pkg::ST_MRD) || (state_q == dsls_pkg::ST_SRD);
    st_raddr   = (state_q == dsls_pkg::ST_SRD) ? base_lv + mid_c : base_lv + a_q;
    sc_we      = (state_q == dsls_pkg::ST_MCMP) || (accept && in_op_i == dsls_pkg::OP_INSERT);
    sc_waddr   = (state_q == dsls_pkg::ST_MCMP) ? {~src_q, ab_sum[IW-1:0]} : '0;
    sc_wdata   = (state_q == dsls_pkg::ST_MCMP) ? (take_carry ? sc_rd_q : st_rd_q)
                                                : in_value_i;
    sc_re      = (state_q == dsls_pkg::ST_MRD) || (state_q == dsls_pkg::ST_CRD);
    sc_raddr   = (state_q == dsls_pkg::ST_CRD) ? {src_q, c_q[IW-1:0]} : {src_q, b_q[IW-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rd_q <= store_mem[st_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sc_we) begin
      scr_mem[sc_waddr] <= sc_wdata;
    end
    if (sc_re) begin
      sc_rd_q <= scr_mem[sc_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dsls_pkg::ST_IDLE;
      full_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == dsls_pkg::ST_MCMP && merge_last) begin
        full_q[lv_q] <= 1'b0;
      end
      if (state_q == dsls_pkg::ST_CWR && copy_last) begin
        full_q[fe_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      dsls_pkg::ST_IDLE: begin
        key_q     <= in_value_i;
        fe_q      <= fe_c;
        lv_q      <= '0;
        src_q     <= 1'b0;
        a_q       <= '0;
        b_q       <= '0;
        c_q       <= '0;
        r_found_q <= 1'b0;
        r_lv_q    <= '0;
        r_pos_q   <= '0;
        r_ovf_q   <= (in_op_i == dsls_pkg::OP_INSERT) && (fe_c == LW'(dsls_pkg::LEVELS));
      end
      dsls_pkg::ST_MCMP: begin
        if (merge_last) begin
          a_q   <= '0;
          b_q   <= '0;
          src_q <= ~src_q;
          lv_q  <= lv_q + LW'(1);
        end else if (take_carry) begin
          b_q <= b_q + AW'(1);
        end else begin
          a_q <= a_q + AW'(1);
        end
      end
      dsls_pkg::ST_CWR: c_q <= c_q + AW'(1);
      dsls_pkg::ST_SCHK: begin
        if (lv_q != LW'(dsls_pkg::LEVELS)) begin
          lo_q <= '0;
          hi_q <= SW'(len) - SW'(1);
          if (!full_q[lv_q]) begin
            lv_q <= lv_q + LW'(1);
          end
        end
      end
      dsls_pkg::ST_SRD: begin
        mid_q <= mid_c;
        if (lo_q > hi_q) begin
          lv_q <= lv_q + LW'(1);
        end
      end
      dsls_pkg::ST_SCMP: begin
        if ($signed(st_rd_q) > key_q) begin
          hi_q <= SW'(mid_q) - SW'(1);
        end else if ($signed(st_rd_q) < key_q) begin
          lo_q <= SW'(mid_q) + SW'(1);
        end else begin
          r_found_q <= 1'b1;
          r_lv_q    <= dsls_pkg::LV_W'(lv_q);
          r_pos_q   <= dsls_pkg::POS_W'(mid_q);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_found_q <= r_found_q;
      out_lv_q    <= r_lv_q;
      out_pos_q   <= r_pos_q;
      out_ovf_q   <= r_ovf_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_found_o    = out_found_q;
  assign out_level_o    = out_lv_q;
  assign out_position_o = out_pos_q;
  assign out_overflow_o = out_ovf_q;

endmodule

// File: hw/rtl/dsls_checker.sv
`include "dynamic_sorted_levels_set_macros.svh"

module dsls_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       out_found_o,
  input logic [dsls_pkg::LV_W-1:0]  out_level_o,
  input logic [dsls_pkg::POS_W-1:0] out_position_o,
  input logic                       out_overflow_o
);

  `DSLS_ASSERT_NOW(a_found_no_ovf, out_valid_o, !(out_found_o && out_overflow_o), "found with overflow")
  `DSLS_ASSERT_NOW(a_miss_zero, out_valid_o && !out_found_o, (out_level_o == '0) && (out_position_o == '0), "miss with nonzero level or position")
  `DSLS_ASSERT_NOW(a_level_range, out_valid_o && out_found_o, out_level_o < dsls_pkg::LV_W'(dsls_pkg::LEVELS), "level beyond top")
  `DSLS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_found_o) && $stable(out_level_o) && $stable(out_position_o), "stalled result changed")
  `DSLS_ASSERT_NEXT(a_busy_after_take, in_valid_i && !in_stall_o, in_stall_o, "second transfer before result")

endmodule

bind dynamic_sorted_levels_set dsls_checker u_dsls_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_found_o    (out_found_o),
  .out_level_o    (out_level_o),
  .out_position_o (out_position_o),
  .out_overflow_o (out_overflow_o)
);
